### sv/gcob_pkg.sv
// Shared types, register indexes and the divide-by-255 helper for the glyph blend.
package gcob_pkg;

    localparam int LANES = 3;

    localparam logic [1:0] REG_TEXT_RED   = 2'd0;
    localparam logic [1:0] REG_TEXT_GREEN = 2'd1;
    localparam logic [1:0] REG_TEXT_BLUE  = 2'd2;
    localparam logic [1:0] REG_TEXT_ALPHA = 2'd3;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // ceil(2^32 / 255); exact floor(x / 255) for every x below 2^24
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    typedef logic [16:0] num_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic       bypass;
        pixel_t     dst;
        logic [7:0] out_alpha;
    } side_t;

    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [48:0] prod;
        prod = 49'(x) * 49'(RECIP_255);
        return prod[47:32];
    endfunction

endpackage

### sv/gcob_div.sv
// Pipelined saturating restoring divider for the three colour lanes, with final pixel select.
module gcob_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gcob_pkg::num_t     num [gcob_pkg::LANES],
    input  logic [7:0]         den,
    input  gcob_pkg::side_t    side,
    output logic               out_valid,
    input  logic               out_ready,
    output gcob_pkg::pixel_t   result
);

    // stage 0: overflow check, stages 1..3: two quotient bits each, stage 4: last two bits
    localparam int MID    = 4;
    localparam int STAGES = MID + 1;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;

    logic [15:0]           rem_reg  [MID][gcob_pkg::LANES];
    logic [15:0]           rem_next [MID][gcob_pkg::LANES];
    logic [7:0]            q_reg    [MID][gcob_pkg::LANES];
    logic [7:0]            q_next   [MID][gcob_pkg::LANES];
    logic                  sat_reg  [MID][gcob_pkg::LANES];
    logic                  sat_next [gcob_pkg::LANES];
    logic [7:0]            den_reg  [MID];
    gcob_pkg::side_t       side_reg [MID];
    gcob_pkg::pixel_t      res_reg;
    gcob_pkg::pixel_t      res_next;

    function automatic logic [23:0] step2(input logic [15:0] rem, input logic [7:0] q,
                                          input logic [7:0] d, input int hi);
        logic [15:0] r;
        logic [7:0]  qq;
        logic [15:0] sh;
        r  = rem;
        qq = q;
        for (int j = 0; j < 2; j++) begin
            sh = 16'(d) << (hi - j);
            if (r >= sh) begin
                r = r - sh;
                qq[hi - j] = 1'b1;
            end
        end
        return {r, qq};
    endfunction

    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] | out_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            en[s] = !vld_reg[s] | en[s+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];
    assign result    = res_reg;

    always_comb begin
        logic [23:0] fin;
        logic [7:0]  lane_q [gcob_pkg::LANES];
        fin = '0;
        for (int l = 0; l < gcob_pkg::LANES; l++) begin
            // quotient above 255 when num reaches den * 256
            sat_next[l]    = num[l] >= {1'b0, den, 8'd0};
            rem_next[0][l] = num[l][15:0];
            q_next[0][l]   = '0;
            for (int s = 1; s < MID; s++) begin
                {rem_next[s][l], q_next[s][l]} =
                    step2(rem_reg[s-1][l], q_reg[s-1][l], den_reg[s-1], 9 - 2 * s);
            end
            fin       = step2(rem_reg[MID-1][l], q_reg[MID-1][l], den_reg[MID-1], 1);
            lane_q[l] = sat_reg[MID-1][l] ? gcob_pkg::CHAN_MAX : fin[7:0];
        end
        if (side_reg[MID-1].bypass) begin
            res_next = side_reg[MID-1].dst;
        end
        else begin
            res_next.red   = lane_q[0];
            res_next.green = lane_q[1];
            res_next.blue  = lane_q[2];
            res_next.alpha = side_reg[MID-1].out_alpha;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < gcob_pkg::LANES; l++) begin
                rem_reg[0][l] <= rem_next[0][l];
                q_reg[0][l]   <= q_next[0][l];
                sat_reg[0][l] <= sat_next[l];
            end
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
        for (int s = 1; s < MID; s++) begin
            if (en[s])
            begin
                for (int l = 0; l < gcob_pkg::LANES; l++) begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                    sat_reg[s][l] <= sat_reg[s-1][l];
                end
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
        if (en[STAGES-1])
        begin
            res_reg <= res_next;
        end
    end

endmodule

### sv/glyph_coverage_over_blend.sv
// Top level: source-over blend of the text colour onto a pixel stream, weighted by glyph coverage.
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid / tready    coverage, dst_red, dst_green, dst_blue, dst_alpha
//   m_*       out        tvalid / tready    out_red, out_green, out_blue, out_alpha
//   cfg_*     in         cfg_wen            text_red, text_green, text_blue, text_alpha
//
// One word per clock sustained while m_tready holds; eleven register stages: six arithmetic
// stages (alpha products, divides by 255, sums) and five divider stages (overflow check, then
// two quotient bits a stage) for the division by the output alpha.
// Reset clears every valid bit and sets the text colour registers to 255.
// Each stage holds its word until the next one frees up; bubbles close on a stall.
module glyph_coverage_over_blend (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coverage, dst_red, dst_green, dst_blue, dst_alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam int FSTG = 6;

    logic [7:0] text_red_reg;
    logic [7:0] text_green_reg;
    logic [7:0] text_blue_reg;
    logic [7:0] text_alpha_reg;
    logic [7:0] col [gcob_pkg::LANES];

    logic [FSTG-1:0] fvld_reg;
    logic [FSTG-1:0] en;
    logic            div_ready;

    gcob_pkg::pixel_t in_pix;

    // stage 0
    logic             cz0_reg;
    logic [15:0]      aprod0_reg;
    logic [15:0]      aprod0_next;
    gcob_pkg::pixel_t dst0_reg;
    // stage 1
    logic [7:0]       src1_reg;
    logic [7:0]       src1_next;
    logic [7:0]       inv1_reg;
    logic [7:0]       inv1_next;
    logic             cz1_reg;
    gcob_pkg::pixel_t dst1_reg;
    // stage 2
    logic [15:0]      pa2_reg;
    logic [15:0]      pa2_next;
    logic [15:0]      cs2_reg   [gcob_pkg::LANES];
    logic [15:0]      cs2_next  [gcob_pkg::LANES];
    logic [15:0]      dd2_reg   [gcob_pkg::LANES];
    logic [15:0]      dd2_next  [gcob_pkg::LANES];
    logic [7:0]       src2_reg;
    logic [7:0]       inv2_reg;
    logic             cz2_reg;
    gcob_pkg::pixel_t dst2_reg;
    // stage 3
    logic [7:0]       ta3_reg;
    logic [7:0]       ta3_next;
    logic [23:0]      dd3_reg   [gcob_pkg::LANES];
    logic [23:0]      dd3_next  [gcob_pkg::LANES];
    logic [15:0]      cs3_reg   [gcob_pkg::LANES];
    logic [7:0]       src3_reg;
    logic             cz3_reg;
    gcob_pkg::pixel_t dst3_reg;
    // stage 4
    logic [7:0]       oa4_reg;
    logic [7:0]       oa4_next;
    logic [15:0]      tc4_reg   [gcob_pkg::LANES];
    logic [15:0]      tc4_next  [gcob_pkg::LANES];
    logic [15:0]      cs4_reg   [gcob_pkg::LANES];
    logic             cz4_reg;
    gcob_pkg::pixel_t dst4_reg;
    // stage 5
    gcob_pkg::num_t   num5_reg  [gcob_pkg::LANES];
    gcob_pkg::num_t   num5_next [gcob_pkg::LANES];
    logic [7:0]       oa5_reg;
    logic             byp5_reg;
    logic             byp5_next;
    gcob_pkg::pixel_t dst5_reg;

    gcob_pkg::side_t  div_side;
    gcob_pkg::pixel_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_red_reg   <= gcob_pkg::CHAN_MAX;
            text_green_reg <= gcob_pkg::CHAN_MAX;
            text_blue_reg  <= gcob_pkg::CHAN_MAX;
            text_alpha_reg <= gcob_pkg::CHAN_MAX;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                gcob_pkg::REG_TEXT_RED:   text_red_reg   <= cfg_wdata;
                gcob_pkg::REG_TEXT_GREEN: text_green_reg <= cfg_wdata;
                gcob_pkg::REG_TEXT_BLUE:  text_blue_reg  <= cfg_wdata;
                gcob_pkg::REG_TEXT_ALPHA: text_alpha_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign col[0] = text_red_reg;
    assign col[1] = text_green_reg;
    assign col[2] = text_blue_reg;

    assign in_pix.red   = s_tdata[15:8];
    assign in_pix.green = s_tdata[23:16];
    assign in_pix.blue  = s_tdata[31:24];
    assign in_pix.alpha = s_tdata[39:32];

    always_comb begin
        en[FSTG-1] = !fvld_reg[FSTG-1] | div_ready;
        for (int s = FSTG - 2; s >= 0; s--) begin
            en[s] = !fvld_reg[s] | en[s+1];
        end
    end

    assign s_tready = en[0];

    always_comb begin
        logic [8:0]  sum9;
        logic [15:0] src1_quo;
        logic [15:0] ta3_quo;
        aprod0_next = 16'(s_tdata[7:0]) * 16'(text_alpha_reg);
        src1_quo    = gcob_pkg::div255({8'd0, aprod0_reg});
        src1_next   = src1_quo[7:0];
        inv1_next   = gcob_pkg::CHAN_MAX - src1_next;
        pa2_next    = 16'(dst1_reg.alpha) * 16'(inv1_reg);
        ta3_quo     = gcob_pkg::div255({8'd0, pa2_reg});
        ta3_next    = ta3_quo[7:0];
        sum9        = {1'b0, src3_reg} + {1'b0, ta3_reg};
        oa4_next    = sum9[8] ? gcob_pkg::CHAN_MAX : sum9[7:0];
        byp5_next   = cz4_reg | (oa4_reg == 8'd0);
        for (int l = 0; l < gcob_pkg::LANES; l++) begin
            cs2_next[l]  = 16'(col[l]) * 16'(src1_reg);
            dd2_next[l]  = (l == 0) ? 16'(dst1_reg.red)   * 16'(dst1_reg.alpha) :
                           (l == 1) ? 16'(dst1_reg.green) * 16'(dst1_reg.alpha) :
                                      16'(dst1_reg.blue)  * 16'(dst1_reg.alpha);
            dd3_next[l]  = 24'(dd2_reg[l]) * 24'(inv2_reg);
            tc4_next[l]  = gcob_pkg::div255(dd3_reg[l]);
            num5_next[l] = 17'(cs4_reg[l]) + 17'(tc4_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                fvld_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < FSTG; s++) begin
                if (en[s])
                begin
                    fvld_reg[s] <= fvld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cz0_reg    <= (s_tdata[7:0] == 8'd0);
            aprod0_reg <= aprod0_next;
            dst0_reg   <= in_pix;
        end
        if (en[1])
        begin
            src1_reg <= src1_next;
            inv1_reg <= inv1_next;
            cz1_reg  <= cz0_reg;
            dst1_reg <= dst0_reg;
        end
        if (en[2])
        begin
            pa2_reg  <= pa2_next;
            src2_reg <= src1_reg;
            inv2_reg <= inv1_reg;
            cz2_reg  <= cz1_reg;
            dst2_reg <= dst1_reg;
            for (int l = 0; l < gcob_pkg::LANES; l++) begin
                cs2_reg[l] <= cs2_next[l];
                dd2_reg[l] <= dd2_next[l];
            end
        end
        if (en[3])
        begin
            ta3_reg  <= ta3_next;
            src3_reg <= src2_reg;
            cz3_reg  <= cz2_reg;
            dst3_reg <= dst2_reg;
            for (int l = 0; l < gcob_pkg::LANES; l++) begin
                dd3_reg[l] <= dd3_next[l];
                cs3_reg[l] <= cs2_reg[l];
            end
        end
        if (en[4])
        begin
            oa4_reg  <= oa4_next;
            cz4_reg  <= cz3_reg;
            dst4_reg <= dst3_reg;
            for (int l = 0; l < gcob_pkg::LANES; l++) begin
                tc4_reg[l] <= tc4_next[l];
                cs4_reg[l] <= cs3_reg[l];
            end
        end
        if (en[5])
        begin
            oa5_reg  <= oa4_reg;
            byp5_reg <= byp5_next;
            dst5_reg <= dst4_reg;
            for (int l = 0; l < gcob_pkg::LANES; l++) begin
                num5_reg[l] <= num5_next[l];
            end
        end
    end

    assign div_side.bypass    = byp5_reg;
    assign div_side.dst       = dst5_reg;
    assign div_side.out_alpha = oa5_reg;

    gcob_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fvld_reg[FSTG-1]),
        .in_ready  (div_ready),
        .num       (num5_reg),
        .den       (oa5_reg),
        .side      (div_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (res)
    );

    assign m_tdata = {res.alpha, res.blue, res.green, res.red};

endmodule

### tb/tb_glyph_coverage_over_blend.sv
// Self-checking stream testbench for the glyph coverage source-over blend.
module tb_glyph_coverage_over_blend;

    localparam int unsigned FULL = 255;
    localparam int PIPE_CYCLES = 16;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // coverage, dst_red, dst_green, dst_blue, dst_alpha
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // out_red, out_green, out_blue, out_alpha
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = gcob_pkg::REG_TEXT_RED;
    logic [7:0]  cfg_wdata = '0;

    // local copy of the text colour registers
    logic [7:0] txt_red = 8'd255;
    logic [7:0] txt_green = 8'd255;
    logic [7:0] txt_blue = 8'd255;
    logic [7:0] txt_alpha = 8'd255;

    logic [39:0]      dst_pixel_q[$];
    gcob_pkg::pixel_t blended_q[$];
    int               mismatch_count = 0;
    int               src_mode = 0;
    int               snk_mode = 0;
    int               src_wait = 0;
    int               snk_wait = 0;
    int               snk_next;

    glyph_coverage_over_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // mode 0: never idle, 1: a random, possibly empty idle gap for every word, 2: idle now and then
    function automatic int draw_wait(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 14);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] col, input logic [7:0] dst,
                                              input logic [7:0] dst_a, input int unsigned src_a,
                                              input int unsigned out_a);
        int unsigned c;
        int unsigned d;
        int unsigned da;
        int unsigned num;
        int unsigned q;
        c = 32'(col);
        d = 32'(dst);
        da = 32'(dst_a);
        num = c * src_a + (d * da * (FULL - src_a)) / FULL;
        q = num / out_a;
        return (q > FULL) ? 8'd255 : q[7:0];
    endfunction

    function automatic gcob_pkg::pixel_t source_over(input logic [39:0] word);
        gcob_pkg::pixel_t px;
        int unsigned      cov;
        int unsigned      da;
        int unsigned      src_a;
        int unsigned      out_a;
        cov = 32'(word[7:0]);
        px.red = word[15:8];
        px.green = word[23:16];
        px.blue = word[31:24];
        px.alpha = word[39:32];
        da = 32'(px.alpha);
        if (cov != 0)
        begin
            src_a = (cov * 32'(txt_alpha)) / FULL;
            out_a = src_a + (da * (FULL - src_a)) / FULL;
            if (out_a != 0)
            begin
                px.red = blend_chan(txt_red, px.red, px.alpha, src_a, out_a);
                px.green = blend_chan(txt_green, px.green, px.alpha, src_a, out_a);
                px.blue = blend_chan(txt_blue, px.blue, px.alpha, src_a, out_a);
                px.alpha = (out_a > FULL) ? 8'd255 : out_a[7:0];
            end
        end
        return px;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // driver: present the next pixel once its gap has run out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                blended_q.push_back(source_over(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (src_wait != 0)
                begin
                    s_tvalid <= 1'b0;
                    src_wait <= src_wait - 1;
                end
                else if (dst_pixel_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= dst_pixel_q.pop_front();
                    src_wait <= draw_wait(src_mode);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each blended word with the oldest prediction, then stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (blended_q.size() == 0)
                begin
                    $error("unexpected output word %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    check_field("out_red", blended_q[0].red, m_tdata[7:0]);
                    check_field("out_green", blended_q[0].green, m_tdata[15:8]);
                    check_field("out_blue", blended_q[0].blue, m_tdata[23:16]);
                    check_field("out_alpha", blended_q[0].alpha, m_tdata[31:24]);
                    void'(blended_q.pop_front());
                end
                snk_next = draw_wait(snk_mode);
            end
            else if (snk_wait != 0)
                snk_next = snk_wait - 1;
            else
                snk_next = 0;
            snk_wait <= snk_next;
            m_tready <= (snk_next == 0);
        end
    end

    task automatic add_pixel(input logic [7:0] cov, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        dst_pixel_q.push_back({a, b, g, r, cov});
    endtask

    task automatic add_random_pixels(input int count);
        logic [7:0] cov;
        logic [7:0] a;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            cov = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                  (pick == 2) ? 8'($urandom_range(1, 3)) : 8'($urandom);
            pick = $urandom_range(0, 9);
            a = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            add_pixel(cov, 8'($urandom), 8'($urandom), 8'($urandom), a);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            gcob_pkg::REG_TEXT_RED:   txt_red = val;
            gcob_pkg::REG_TEXT_GREEN: txt_green = val;
            gcob_pkg::REG_TEXT_BLUE:  txt_blue = val;
            gcob_pkg::REG_TEXT_ALPHA: txt_alpha = val;
            default: ;
        endcase
    endtask

    task automatic set_text_colour(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] a);
        write_reg(gcob_pkg::REG_TEXT_RED, r);
        write_reg(gcob_pkg::REG_TEXT_GREEN, g);
        write_reg(gcob_pkg::REG_TEXT_BLUE, b);
        write_reg(gcob_pkg::REG_TEXT_ALPHA, a);
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // wait until every queued pixel has come back out of the pipe
    task automatic drain;
        while (dst_pixel_q.size() != 0 || s_tvalid || blended_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] alpha_pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset colour: opaque white
        src_mode = 0;
        snk_mode = 0;
        add_pixel(8'd0, 8'hab, 8'h54, 8'hc3, 8'h3c);
        add_pixel(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        add_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        // truncated output alpha pushes the quotient past 255
        add_pixel(8'd1, 8'd255, 8'd255, 8'd255, 8'd100);
        add_pixel(8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        add_pixel(8'd128, 8'h55, 8'haa, 8'h0f, 8'd0);
        add_pixel(8'd128, 8'h55, 8'haa, 8'hf0, 8'd255);
        add_pixel(8'd254, 8'd1, 8'd128, 8'd254, 8'd1);
        add_random_pixels(80);
        drain();

        // fully transparent black text: output alpha drops to zero on empty pixels
        set_text_colour(8'd0, 8'd0, 8'd0, 8'd0);
        @(negedge clk);
        src_mode = 1;
        snk_mode = 2;
        add_pixel(8'd255, 8'd200, 8'd100, 8'd50, 8'd0);
        add_pixel(8'd255, 8'd200, 8'd100, 8'd50, 8'd255);
        add_random_pixels(90);
        drain();

        set_text_colour(8'd255, 8'd0, 8'd128, 8'd1);
        @(negedge clk);
        src_mode = 2;
        snk_mode = 1;
        add_pixel(8'd200, 8'd12, 8'd34, 8'd56, 8'd0);
        add_pixel(8'd255, 8'd12, 8'd34, 8'd56, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd3);
        add_random_pixels(90);
        drain();

        set_text_colour(8'd0, 8'd255, 8'd0, 8'd255);
        @(negedge clk);
        src_mode = 1;
        snk_mode = 0;
        add_pixel(8'd255, 8'd255, 8'd0, 8'd255, 8'd128);
        add_random_pixels(90);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case ($urandom_range(0, 2))
                0:       alpha_pick = 8'd0;
                1:       alpha_pick = 8'd255;
                default: alpha_pick = 8'($urandom);
            endcase
            set_text_colour(8'($urandom), 8'($urandom), 8'($urandom), alpha_pick);
            @(negedge clk);
            src_mode = $urandom_range(0, 2);
            snk_mode = (ph == 3) ? 0 : $urandom_range(0, 2);
            add_random_pixels(90);
            drain();
        end

        if (mismatch_count == 0)
            $display("[glyph_coverage_over_blend] OK");
        else
            $display("[glyph_coverage_over_blend] ERROR");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("[glyph_coverage_over_blend] ERROR");
        $finish;
    end

endmodule
